FILE: hw/rtl/nfsld_pkg.sv
// Shared constants, types and helpers of the next-fit slot pool with life decay.
// No dependencies; every other file of the block refers to it by scoped names.
package nfsld_pkg;

   localparam int POOL_SIZE   = 64;
   localparam int IDX_W       = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CNT_W       = $clog2(POOL_SIZE + 1);
   localparam int LIFE_W      = 16;
   localparam int RATE_W      = 16;
   localparam int DT_W        = 16;
   localparam int SLOT_W      = 6;
   localparam int PROD_W      = RATE_W + DT_W;
   localparam int DECAY_SHIFT = 9;
   localparam int DEC_W       = PROD_W - DECAY_SHIFT;

   localparam logic [LIFE_W-1:0] LIFE_FULL  = 16'h8000;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'h0100;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LIFE_W-1:0] life_type;

   // One cycle of access to the life store.
   typedef struct packed {
      logic     rd_en;
      idx_type  rd_addr;
      logic     wr_en;
      idx_type  wr_addr;
      life_type wr_data;
   } ram_req_type;

   // Life after one tick: clamp at zero, keep free slots free.
   function automatic life_type decay_life(life_type life, logic [DEC_W-1:0] dec);
      logic [DEC_W-1:0] life_ext;
      life_ext = DEC_W'(life);
      if (life == '0 || dec >= life_ext) begin
         decay_life = '0;
      end else begin
         decay_life = life - dec[LIFE_W-1:0];
      end
   endfunction

   // Slot field: the index masked or extended to the output width.
   function automatic logic [SLOT_W-1:0] to_slot(idx_type idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {SLOT_W'(0), idx};
      to_slot = ext[SLOT_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/nfsld_life_ram.sv
// Life store of the slot pool: one write port, one read port, registered read.
// Depends on nfsld_pkg; per-entry valid flops make unwritten entries read as zero.
module nfsld_life_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  nfsld_pkg::ram_req_type ram_req,
   output nfsld_pkg::life_type   rd_data
);

   nfsld_pkg::life_type mem [nfsld_pkg::POOL_SIZE];
   logic [nfsld_pkg::POOL_SIZE-1:0] valid_ff;
   logic [nfsld_pkg::POOL_SIZE-1:0] valid_in;
   nfsld_pkg::life_type rd_data_ff;
   logic                rd_hit_ff;
   logic                rd_hit_in;

   always_comb begin
      valid_in = valid_ff;
      if (ram_req.wr_en) begin
         valid_in[ram_req.wr_addr] = 1'b1;
      end
   end

   assign rd_hit_in = ram_req.rd_en ? valid_ff[ram_req.rd_addr] : rd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/nfsld_ctrl.sv
// Sequencer of the slot pool: decay multiply, tick sweep, next-fit scan, result register.
// Depends on nfsld_pkg; drives the life store through one ram_req_type per cycle.
module nfsld_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [nfsld_pkg::DT_W-1:0]       req_delta_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nfsld_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                             rsp_reused_live,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nfsld_pkg::RATE_W-1:0]     csr_data,
   output nfsld_pkg::ram_req_type           ram_req,
   input  nfsld_pkg::life_type              rd_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_TICK = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [nfsld_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [nfsld_pkg::DT_W-1:0]   dt_ff, dt_in;
   logic [nfsld_pkg::DEC_W-1:0]  dec_ff, dec_in;
   logic [nfsld_pkg::PROD_W-1:0] prod;
   nfsld_pkg::idx_type           start_ff, start_in;
   nfsld_pkg::idx_type           iss_addr_ff, iss_addr_in, iss_next;
   logic [nfsld_pkg::CNT_W-1:0]  iss_cnt_ff, iss_cnt_in;
   logic                         chk_vld_ff, chk_vld_in;
   nfsld_pkg::idx_type           chk_addr_ff, chk_addr_in;
   nfsld_pkg::idx_type           found_ff, found_in;
   logic                         reused_ff, reused_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nfsld_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                         rsp_reused_ff, rsp_reused_in;
   logic                         accept, out_free, issuing, sweep_done;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign prod      = nfsld_pkg::PROD_W'(rate_ff) * nfsld_pkg::PROD_W'(dt_ff);
   assign iss_next  = (iss_addr_ff == nfsld_pkg::IDX_W'(nfsld_pkg::POOL_SIZE - 1))
                      ? '0 : iss_addr_ff + nfsld_pkg::IDX_W'(1);
   assign sweep_done = (iss_cnt_ff == nfsld_pkg::CNT_W'(nfsld_pkg::POOL_SIZE)) && !chk_vld_ff;

   always_comb begin
      state_in      = state_ff;
      rate_in       = (csr_valid && csr_ready) ? csr_data : rate_ff;
      dt_in         = dt_ff;
      dec_in        = dec_ff;
      start_in      = start_ff;
      iss_addr_in   = iss_addr_ff;
      iss_cnt_in    = iss_cnt_ff;
      chk_vld_in    = 1'b0;
      chk_addr_in   = chk_addr_ff;
      found_in      = found_ff;
      reused_in     = reused_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_reused_in = rsp_reused_ff;
      ram_req       = '0;
      issuing       = (iss_cnt_ff != nfsld_pkg::CNT_W'(nfsld_pkg::POOL_SIZE));

      case (state_ff)
         ST_IDLE: begin
            iss_cnt_in = '0;
            if (accept) begin
               dt_in = req_delta_time;
               if (req_mode == nfsld_pkg::MODE_TICK) begin
                  iss_addr_in = '0;
                  state_in    = ST_MUL;
               end else begin
                  iss_addr_in = start_ff;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_MUL: begin
            // register the decay before the sweep
            dec_in   = prod[nfsld_pkg::PROD_W-1:nfsld_pkg::DECAY_SHIFT];
            state_in = ST_TICK;
         end
         ST_TICK: begin
            // read one slot ahead, write back the slot read last cycle
            if (issuing) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = iss_addr_ff;
               chk_vld_in      = 1'b1;
               chk_addr_in     = iss_addr_ff;
               iss_addr_in     = iss_next;
               iss_cnt_in      = iss_cnt_ff + nfsld_pkg::CNT_W'(1);
            end
            if (chk_vld_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = chk_addr_ff;
               ram_req.wr_data = nfsld_pkg::decay_life(rd_data, dec_ff);
            end
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && rd_data == '0) begin
               found_in  = chk_addr_ff;
               reused_in = 1'b0;
               state_in  = ST_DONE;
            end else if (sweep_done) begin
               found_in  = '0;
               reused_in = 1'b1;
               state_in  = ST_DONE;
            end else if (issuing) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = iss_addr_ff;
               chk_vld_in      = 1'b1;
               chk_addr_in     = iss_addr_ff;
               iss_addr_in     = iss_next;
               iss_cnt_in      = iss_cnt_ff + nfsld_pkg::CNT_W'(1);
            end
         end
         ST_DONE: begin
            // hold until the result register is free, then claim the slot
            if (out_free) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = found_ff;
               ram_req.wr_data = nfsld_pkg::LIFE_FULL;
               if (!reused_ff) begin
                  start_in = found_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = nfsld_pkg::to_slot(found_ff);
               rsp_reused_in = reused_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= nfsld_pkg::RATE_RESET;
         start_ff     <= '0;
         iss_cnt_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         start_ff     <= start_in;
         iss_cnt_ff   <= iss_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      dec_ff        <= dec_in;
      iss_addr_ff   <= iss_addr_in;
      chk_addr_ff   <= chk_addr_in;
      found_ff      <= found_in;
      reused_ff     <= reused_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_reused_live = rsp_reused_ff;

   a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
      else $error("life store read and write hit the same slot");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_req.wr_en)
      else $error("life store written during a scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the claim step");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      iss_cnt_ff <= nfsld_pkg::CNT_W'(nfsld_pkg::POOL_SIZE))
      else $error("issue count ran past the pool");

   a_reused_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && reused_ff) |-> (found_ff == '0))
      else $error("full-pool reuse not aimed at slot zero");

endmodule

FILE: hw/rtl/next_fit_slot_pool_life_decay.sv
// Top level of the next-fit slot pool with life decay.
// Depends on nfsld_pkg, nfsld_life_ram and nfsld_ctrl.
//
// Use:
//   req channel (req_valid / req_stall): one item per handshake. req_mode 0 allocates a
//   slot, req_mode 1 is a time tick of req_delta_time (Q0.16 seconds).
//   rsp channel (rsp_valid / rsp_stall): one item per allocate, none per tick, carrying
//   rsp_slot and rsp_reused_live (pool full, slot 0 overwritten).
//   csr channel (csr_valid / csr_ready): writes decay_rate (Q8.8 life per second);
//   csr_ready is always high. Write only while the block is idle.
// Timing: one item is in work at a time; req_stall is high while it runs. A tick first
//   registers the decay product, then a sweep reads one slot and writes back the previous
//   one each cycle on the life store's two ports.
//   An allocate looks at slots from the search pointer on, one per cycle on the read port
//   of the life store, then claims the first free one, or slot 0 when none is free.
// Reset: life store reads all zero at once (per-slot valid flops), search pointer 0,
//   decay_rate 256. No clearing pass.
// Stall: a result sits in the output register; a following tick proceeds, an allocate
//   waits in its claim step until the register frees.
module next_fit_slot_pool_life_decay (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [nfsld_pkg::DT_W-1:0]       req_delta_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nfsld_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                             rsp_reused_live,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nfsld_pkg::RATE_W-1:0]     csr_data
);

   // access of the sequencer to the life store, and the registered read data
   nfsld_pkg::ram_req_type ram_req;
   nfsld_pkg::life_type    rd_data;

   nfsld_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_delta_time  (req_delta_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_reused_live (rsp_reused_live),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .ram_req         (ram_req),
      .rd_data         (rd_data)
   );

   // one life value per slot
   nfsld_life_ram u_life_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule
